### rtl/core/sdit_pkg.sv
// Shared widths, types and helpers for the Sampson distance inlier test.
package sdit_pkg;

  localparam int COORD_BITS = 16;
  localparam int COEF_BITS  = 21;
  localparam int FRAC_BITS  = 4;

  localparam int ROW_W      = 63;
  localparam int THR_W      = 16;
  localparam int FLOOR_W    = 32;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;

  // Epipolar line terms: signed coefficient times unsigned coordinate
  localparam int PROD_W = COEF_BITS + COORD_BITS + 1;
  localparam int LINE_W = PROD_W + 2;
  localparam int LMAG_W = LINE_W - 1;
  localparam int LL_W   = LMAG_W / 2;
  localparam int LH_W   = LMAG_W - LL_W;
  localparam int SQ_W   = 2 * LMAG_W;
  localparam int DEN_W  = SQ_W + 2;

  // Residual p2^T F p1
  localparam int TERM_W = LINE_W + COORD_BITS + 1;
  localparam int NUM_W  = TERM_W + 2;
  localparam int NMAG_W = NUM_W - 1;
  localparam int NL_W   = NMAG_W / 2;
  localparam int NH_W   = NMAG_W - NL_W;
  localparam int NSQ_W  = 2 * NMAG_W;

  // Threshold times denominator, split in two halves of the denominator
  localparam int DL_W   = DEN_W / 2;
  localparam int DH_W   = DEN_W - DL_W;
  localparam int TDEN_W = THR_W + DEN_W;
  localparam int CMP_W  = (NSQ_W > TDEN_W) ? NSQ_W : TDEN_W;

  localparam int NSTAGE = 9;
  localparam int SEG    = 3;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd2304;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ZERO  = 3'd0,
    REG_ROW_ONE   = 3'd1,
    REG_ROW_TWO   = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_FLOOR     = 3'd4
  } cfg_reg_t;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [LINE_W-1:0]   line_t;
  typedef logic [SEG-1:0]             seg_en_t;
  typedef logic [NSTAGE-1:0]          stage_vec_t;

  typedef struct packed {
    coef_t f00, f01, f02;
    coef_t f10, f11, f12;
    coef_t f20, f21, f22;
  } coef_set_t;

  typedef struct packed {
    line_t l2x, l2y, l2z;
    line_t l1x, l1y;
  } line_set_t;

  typedef struct packed {
    logic [2*LH_W-1:0]      hh;
    logic [LH_W+LL_W-1:0]   hl;
    logic [2*LL_W-1:0]      ll;
  } lsq_part_t;

  typedef struct packed {
    logic [2*NH_W-1:0]      hh;
    logic [NH_W+NL_W-1:0]   hl;
    logic [2*NL_W-1:0]      ll;
  } nsq_part_t;

  function automatic coef_set_t unpack_coefs(input logic [ROW_W-1:0] r0,
                                             input logic [ROW_W-1:0] r1,
                                             input logic [ROW_W-1:0] r2);
    coef_set_t c;
    c.f00 = r0[0*COEF_BITS +: COEF_BITS];
    c.f01 = r0[1*COEF_BITS +: COEF_BITS];
    c.f02 = r0[2*COEF_BITS +: COEF_BITS];
    c.f10 = r1[0*COEF_BITS +: COEF_BITS];
    c.f11 = r1[1*COEF_BITS +: COEF_BITS];
    c.f12 = r1[2*COEF_BITS +: COEF_BITS];
    c.f20 = r2[0*COEF_BITS +: COEF_BITS];
    c.f21 = r2[1*COEF_BITS +: COEF_BITS];
    c.f22 = r2[2*COEF_BITS +: COEF_BITS];
    return c;
  endfunction

  // Magnitude of a line value; headroom keeps it clear of the most negative code
  function automatic logic [LMAG_W-1:0] line_mag(input line_t l);
    line_t neg;
    neg = -l;
    return l[LINE_W-1] ? neg[LMAG_W-1:0] : l[LMAG_W-1:0];
  endfunction

  function automatic lsq_part_t line_sq_parts(input logic [LMAG_W-1:0] m);
    lsq_part_t p;
    logic [LH_W-1:0] h;
    logic [LL_W-1:0] lo;
    h    = m[LMAG_W-1:LL_W];
    lo   = m[LL_W-1:0];
    p.hh = (2*LH_W)'(h) * (2*LH_W)'(h);
    p.hl = (LH_W+LL_W)'(h) * (LH_W+LL_W)'(lo);
    p.ll = (2*LL_W)'(lo) * (2*LL_W)'(lo);
    return p;
  endfunction

  // (h*2^L + lo)^2 = h^2*2^2L + 2*h*lo*2^L + lo^2
  function automatic logic [SQ_W-1:0] line_sq(input lsq_part_t p);
    return (SQ_W'(p.hh) << (2*LL_W)) + (SQ_W'(p.hl) << (LL_W+1)) + SQ_W'(p.ll);
  endfunction

endpackage

### rtl/core/sdit_ctrl.sv
// Valid bits and per-stage load enables for the nine-stage pipeline.
module sdit_ctrl
  import sdit_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output stage_vec_t en
);

  stage_vec_t v_r;
  stage_vec_t v_nxt;

  // A stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt    = v_r;
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTAGE-1];

endmodule

### rtl/core/sdit_lines.sv
// Stages 0-2: input capture, coefficient products and the five epipolar line terms.
module sdit_lines
  import sdit_pkg::*;
(
  input  logic      clk,
  input  seg_en_t   en,
  input  coef_set_t coefs,
  input  coord_t    first_x,
  input  coord_t    first_y,
  input  coord_t    second_x,
  input  coord_t    second_y,
  output line_set_t lines,
  output coord_t    x2_o,
  output coord_t    y2_o
);

  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic prod_t mul_fc(input coef_t f, input coord_t x);
    prod_t a;
    prod_t b;
    a = PROD_W'(f);
    b = PROD_W'({1'b0, x});
    return a * b;
  endfunction

  // stage 0
  coord_t x1_r, y1_r, x2_r, y2_r;
  // stage 1
  prod_t  p_r [10];
  prod_t  p_nxt [10];
  coord_t x2_s1_r, y2_s1_r;
  // stage 2
  line_set_t lines_r;
  line_set_t lines_nxt;
  coord_t    x2_s2_r, y2_s2_r;

  always_comb begin
    p_nxt[0] = mul_fc(coefs.f00, x1_r);
    p_nxt[1] = mul_fc(coefs.f01, y1_r);
    p_nxt[2] = mul_fc(coefs.f10, x1_r);
    p_nxt[3] = mul_fc(coefs.f11, y1_r);
    p_nxt[4] = mul_fc(coefs.f20, x1_r);
    p_nxt[5] = mul_fc(coefs.f21, y1_r);
    p_nxt[6] = mul_fc(coefs.f00, x2_r);
    p_nxt[7] = mul_fc(coefs.f10, y2_r);
    p_nxt[8] = mul_fc(coefs.f01, x2_r);
    p_nxt[9] = mul_fc(coefs.f11, y2_r);
  end

  always_comb begin
    lines_nxt.l2x = LINE_W'(p_r[0]) + LINE_W'(p_r[1]) + (LINE_W'(coefs.f02) <<< FRAC_BITS);
    lines_nxt.l2y = LINE_W'(p_r[2]) + LINE_W'(p_r[3]) + (LINE_W'(coefs.f12) <<< FRAC_BITS);
    lines_nxt.l2z = LINE_W'(p_r[4]) + LINE_W'(p_r[5]) + (LINE_W'(coefs.f22) <<< FRAC_BITS);
    lines_nxt.l1x = LINE_W'(p_r[6]) + LINE_W'(p_r[7]) + (LINE_W'(coefs.f20) <<< FRAC_BITS);
    lines_nxt.l1y = LINE_W'(p_r[8]) + LINE_W'(p_r[9]) + (LINE_W'(coefs.f21) <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r <= first_x;
      y1_r <= first_y;
      x2_r <= second_x;
      y2_r <= second_y;
    end
    if (en[1]) begin
      p_r     <= p_nxt;
      x2_s1_r <= x2_r;
      y2_s1_r <= y2_r;
    end
    if (en[2]) begin
      lines_r <= lines_nxt;
      x2_s2_r <= x2_s1_r;
      y2_s2_r <= y2_s1_r;
    end
  end

  assign lines = lines_r;
  assign x2_o  = x2_s2_r;
  assign y2_o  = y2_s2_r;

endmodule

### rtl/core/sdit_terms.sv
// Stages 3-5: residual terms and sum, line squares and the Sampson denominator.
module sdit_terms
  import sdit_pkg::*;
(
  input  logic             clk,
  input  seg_en_t          en,
  input  line_set_t        lines,
  input  coord_t           x2,
  input  coord_t           y2,
  output nsq_part_t        nparts,
  output logic [DEN_W-1:0] den
);

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  // stage 3
  term_t     t0_r, t1_r, t2_r;
  term_t     t0_nxt, t1_nxt;
  lsq_part_t lsq_r [4];
  lsq_part_t lsq_nxt [4];
  line_t     den_lines [4];
  // stage 4
  num_t            num_r;
  num_t            num_nxt;
  logic [SQ_W-1:0] sq_r [4];
  logic [SQ_W-1:0] sq_nxt [4];
  // stage 5
  nsq_part_t        nparts_r;
  nsq_part_t        nparts_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] den_nxt;
  num_t             num_neg;
  logic [NMAG_W-1:0] nmag;
  logic [NH_W-1:0]  nh;
  logic [NL_W-1:0]  nl;

  assign den_lines[0] = lines.l2x;
  assign den_lines[1] = lines.l2y;
  assign den_lines[2] = lines.l1x;
  assign den_lines[3] = lines.l1y;

  always_comb begin
    t0_nxt = TERM_W'(lines.l2x) * TERM_W'({1'b0, x2});
    t1_nxt = TERM_W'(lines.l2y) * TERM_W'({1'b0, y2});
    for (int i = 0; i < 4; i++) begin
      lsq_nxt[i] = line_sq_parts(line_mag(den_lines[i]));
    end
  end

  always_comb begin
    num_nxt = NUM_W'(t0_r) + NUM_W'(t1_r) + NUM_W'(t2_r);
    for (int i = 0; i < 4; i++) begin
      sq_nxt[i] = line_sq(lsq_r[i]);
    end
  end

  always_comb begin
    num_neg       = -num_r;
    nmag          = num_r[NUM_W-1] ? num_neg[NMAG_W-1:0] : num_r[NMAG_W-1:0];
    nh            = nmag[NMAG_W-1:NL_W];
    nl            = nmag[NL_W-1:0];
    nparts_nxt.hh = (2*NH_W)'(nh) * (2*NH_W)'(nh);
    nparts_nxt.hl = (NH_W+NL_W)'(nh) * (NH_W+NL_W)'(nl);
    nparts_nxt.ll = (2*NL_W)'(nl) * (2*NL_W)'(nl);
    den_nxt       = (DEN_W'(sq_r[0]) + DEN_W'(sq_r[1])) + (DEN_W'(sq_r[2]) + DEN_W'(sq_r[3]));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r  <= t0_nxt;
      t1_r  <= t1_nxt;
      t2_r  <= TERM_W'(lines.l2z) <<< FRAC_BITS;
      lsq_r <= lsq_nxt;
    end
    if (en[1]) begin
      num_r <= num_nxt;
      sq_r  <= sq_nxt;
    end
    if (en[2]) begin
      nparts_r <= nparts_nxt;
      den_r    <= den_nxt;
    end
  end

  assign nparts = nparts_r;
  assign den    = den_r;

endmodule

### rtl/core/sdit_decide.sv
// Stages 6-8: residual square, threshold times denominator, floor check and verdict.
module sdit_decide
  import sdit_pkg::*;
(
  input  logic               clk,
  input  seg_en_t            en,
  input  nsq_part_t          nparts,
  input  logic [DEN_W-1:0]   den,
  input  logic [THR_W-1:0]   thr,
  input  logic [FLOOR_W-1:0] floor_val,
  output logic               is_inlier,
  output logic               is_degenerate
);

  // stage 6
  logic [NSQ_W-1:0]       nsq_r;
  logic [NSQ_W-1:0]       nsq_nxt;
  logic [THR_W+DH_W-1:0]  tdh_r;
  logic [THR_W+DH_W-1:0]  tdh_nxt;
  logic [THR_W+DL_W-1:0]  tdl_r;
  logic [THR_W+DL_W-1:0]  tdl_nxt;
  logic                   degen6_r;
  // stage 7
  logic [NSQ_W-1:0]       nsq7_r;
  logic [TDEN_W-1:0]      tden_r;
  logic [TDEN_W-1:0]      tden_nxt;
  logic                   degen7_r;
  // stage 8
  logic                   inlier_r;
  logic                   inlier_nxt;
  logic                   degen_r;

  always_comb begin
    nsq_nxt = (NSQ_W'(nparts.hh) << (2*NL_W)) + (NSQ_W'(nparts.hl) << (NL_W+1))
            + NSQ_W'(nparts.ll);
    tdh_nxt = (THR_W+DH_W)'(thr) * (THR_W+DH_W)'(den[DEN_W-1:DL_W]);
    tdl_nxt = (THR_W+DL_W)'(thr) * (THR_W+DL_W)'(den[DL_W-1:0]);
  end

  assign tden_nxt   = (TDEN_W'(tdh_r) << DL_W) + TDEN_W'(tdl_r);
  // a degenerate request is never an inlier
  assign inlier_nxt = !degen7_r && (CMP_W'(nsq7_r) < CMP_W'(tden_r));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nsq_r    <= nsq_nxt;
      tdh_r    <= tdh_nxt;
      tdl_r    <= tdl_nxt;
      degen6_r <= den < DEN_W'(floor_val);
    end
    if (en[1]) begin
      nsq7_r   <= nsq_r;
      tden_r   <= tden_nxt;
      degen7_r <= degen6_r;
    end
    if (en[2]) begin
      inlier_r <= inlier_nxt;
      degen_r  <= degen7_r;
    end
  end

  assign is_inlier     = inlier_r;
  assign is_degenerate = degen_r;

endmodule

### rtl/core/sampson_distance_inlier_test_top.sv
// Top level: configuration registers and the nine-stage Sampson inlier pipeline.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------------------
//   in      | in  | in_valid / in_stall | in_first_x, in_first_y, in_second_x, in_second_y
//   out     | out | out_valid/out_stall | out_is_inlier, out_is_degenerate
//   cfg     | in  | cfg_wr_en           | cfg_index, cfg_data
//
// One request per clock while in_stall is low; a result is shown once its request has passed every register stage.
// Nine register stages; the widest step is one 29x29 partial product of the residual square.
// Reset clears the stage valid bits, zeroes F, sets threshold 2304 and floor 1.
// Only full stages hold on out_stall, so bubbles close up; in_stall rises only when
// all nine stages hold requests and the output is stalled.
module sampson_distance_inlier_test_top
  import sdit_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_inlier,
  output logic                  out_is_degenerate,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ROW_W-1:0]   row0_r, row1_r, row2_r;
  logic [THR_W-1:0]   thr_r;
  logic [FLOOR_W-1:0] floor_r;

  coef_set_t        coefs;
  stage_vec_t       en;
  line_set_t        lines;
  coord_t           x2_s2, y2_s2;
  nsq_part_t        nparts;
  logic [DEN_W-1:0] den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r  <= '0;
      row1_r  <= '0;
      row2_r  <= '0;
      thr_r   <= THR_RESET;
      floor_r <= FLOOR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_ZERO:  row0_r  <= cfg_data[ROW_W-1:0];
        REG_ROW_ONE:   row1_r  <= cfg_data[ROW_W-1:0];
        REG_ROW_TWO:   row2_r  <= cfg_data[ROW_W-1:0];
        REG_THRESHOLD: thr_r   <= cfg_data[THR_W-1:0];
        REG_FLOOR:     floor_r <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign coefs = unpack_coefs(row0_r, row1_r, row2_r);

  sdit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  sdit_lines u_lines (
    .clk      (clk),
    .en       (en[2:0]),
    .coefs    (coefs),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .lines    (lines),
    .x2_o     (x2_s2),
    .y2_o     (y2_s2)
  );

  sdit_terms u_terms (
    .clk    (clk),
    .en     (en[5:3]),
    .lines  (lines),
    .x2     (x2_s2),
    .y2     (y2_s2),
    .nparts (nparts),
    .den    (den)
  );

  sdit_decide u_decide (
    .clk           (clk),
    .en            (en[8:6]),
    .nparts        (nparts),
    .den           (den),
    .thr           (thr_r),
    .floor_val     (floor_r),
    .is_inlier     (out_is_inlier),
    .is_degenerate (out_is_degenerate)
  );

endmodule

### rtl/core/sdit_checker.sv
// Port-level checks for the Sampson inlier test, bound to the top level.
module sdit_props (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_is_inlier,
  input logic out_is_degenerate
);

  // reset empties the pipe and opens the input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  // input backs up only when the output is held and every stage is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_degenerate |-> !out_is_inlier)
    else $error("degenerate request reported as inlier");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_inlier)
                               && $stable(out_is_degenerate))
    else $error("stalled result changed");

endmodule

bind sampson_distance_inlier_test_top sdit_props u_sdit_props (.*);
